// File: hdl/jse_pkg.sv
package jse_pkg;

	localparam int unsigned RunMax = 6;
	localparam int unsigned CntW   = $clog2(RunMax + 1);

	typedef enum logic [1:0] {
		OpStart = 2'd0,
		OpChar  = 2'd1,
		OpEnd   = 2'd2
	} jse_op_t;

	localparam logic [7:0] CtrlLimit  = 8'h20;
	localparam logic [7:0] ChQuote    = 8'h22;
	localparam logic [7:0] ChBslash   = 8'h5C;
	localparam logic [7:0] ChSlash    = 8'h2F;
	localparam logic [7:0] ChLess     = 8'h3C;
	localparam logic [7:0] ChDot      = 8'h2E;
	localparam logic [7:0] ChUnder    = 8'h5F;
	localparam logic [7:0] ChB        = 8'h62;
	localparam logic [7:0] ChT        = 8'h74;
	localparam logic [7:0] ChN        = 8'h6E;
	localparam logic [7:0] ChF        = 8'h66;
	localparam logic [7:0] ChR        = 8'h72;
	localparam logic [7:0] ChU        = 8'h75;
	localparam logic [7:0] ChZero     = 8'h30;
	localparam logic [7:0] ChLowA     = 8'h61;

	localparam logic [7:0] CtrlBs = 8'h08;
	localparam logic [7:0] CtrlHt = 8'h09;
	localparam logic [7:0] CtrlLf = 8'h0A;
	localparam logic [7:0] CtrlFf = 8'h0C;
	localparam logic [7:0] CtrlCr = 8'h0D;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] char_byte;
	} jse_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} jse_out_t;

	typedef struct packed {
		logic [RunMax-1:0][7:0] bytes;
		logic [CntW-1:0]        cnt;
	} jse_run_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = ChZero + {4'd0, nib};
		end else begin
			r = ChLowA + {4'd0, nib} - 8'd10;
		end
		return r;
	endfunction

endpackage

// File: hdl/jse_encoder.sv
module jse_encoder
	import jse_pkg::*;
(
	input  jse_in_t  word,
	input  logic     prev_lt,
	input  logic     dot_mode,
	output jse_run_t run,
	output logic     prev_lt_next
);

	logic [7:0] c;

	assign c = word.char_byte;

	always_comb begin
		run          = '0;
		prev_lt_next = prev_lt;
		case (word.operation) inside
			OpStart, OpEnd: begin
				run.bytes[0] = ChQuote;
				run.cnt      = CntW'(1);
				prev_lt_next = 1'b0;
			end
			OpChar: begin
				prev_lt_next = (c == ChLess);
				if (c < CtrlLimit) begin
					run.bytes[0] = ChBslash;
					run.cnt      = CntW'(2);
					case (c)
						CtrlBs: run.bytes[1] = ChB;
						CtrlHt: run.bytes[1] = ChT;
						CtrlLf: run.bytes[1] = ChN;
						CtrlFf: run.bytes[1] = ChF;
						CtrlCr: run.bytes[1] = ChR;
						default: begin
							run.bytes[1] = ChU;
							run.bytes[2] = ChZero;
							run.bytes[3] = ChZero;
							run.bytes[4] = hex_char(c[7:4]);
							run.bytes[5] = hex_char(c[3:0]);
							run.cnt      = CntW'(RunMax);
						end
					endcase
				end else if ((c == ChSlash) && prev_lt) begin
					run.bytes[0] = ChBslash;
					run.bytes[1] = ChSlash;
					run.cnt      = CntW'(2);
				end else if ((c == ChBslash) || (c == ChQuote)) begin
					run.bytes[0] = ChBslash;
					run.bytes[1] = c;
					run.cnt      = CntW'(2);
				end else if ((c == ChDot) && dot_mode) begin
					run.bytes[0] = ChUnder;
					run.cnt      = CntW'(1);
				end else begin
					run.bytes[0] = c;
					run.cnt      = CntW'(1);
				end
			end
			default: begin
				run = '0;
			end
		endcase
	end

endmodule

// File: hdl/jse_serializer.sv
module jse_serializer
	import jse_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load_valid,
	input  jse_run_t run,
	output logic     load_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output jse_out_t out_data
);

	logic [RunMax-1:0][7:0] bytes_q;
	logic [CntW-1:0]        cnt_q;
	logic                   busy;
	logic                   last;
	logic                   take;
	logic                   load;

	assign busy       = (cnt_q != '0);
	assign last       = (cnt_q == CntW'(1));
	assign take       = busy && out_ready;
	assign load_ready = !busy || (out_ready && last);
	assign load       = load_valid && load_ready;

	assign out_valid            = busy;
	assign out_data.out_byte    = bytes_q[0];
	assign out_data.last_of_run = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= run.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	// advance one byte per taken word
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= run.bytes;
		end else if (take) begin
			bytes_q <= {8'd0, bytes_q[RunMax-1:1]};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(RunMax))
		else $error("run count out of range");

	a_hold_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !last) |-> !load_ready)
		else $error("load accepted in the middle of a run");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !last) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
		else $error("run count did not step down");

endmodule

// File: hdl/json_string_escaper.sv
// JSON string escaper.
// Input channel in_valid/in_ready/in_data carries one word per item: a
// start, a character or an end operation with its byte. Output channel
// out_valid/out_ready/out_data carries one escaped byte per word, with
// last_of_run set on the final byte that an input word causes. Start and
// end emit a double quote; a character emits one to six bytes; operation
// code 3 emits nothing. cfg_valid/cfg_ready/cfg_data writes the dot mode
// register; write it only while the block is idle.
// An accepted word passes the input register and the encoder into the
// output register. Throughput: one input word per cycle while every run
// is a single byte and the receiver is ready; a longer run holds the
// output register until its last byte is taken, while one more input
// word waits in the input register. When the receiver stalls, the current
// byte holds and input backs up through the input register to in_ready.
// Reset empties the input and output registers (their data is not reset)
// and clears the dot mode and the look-behind flag for the slash escape.
module json_string_escaper
	import jse_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  jse_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output jse_out_t out_data,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     cfg_data
);

	logic     valid_s1;
	jse_in_t  word_s1;
	logic     dot_q;
	logic     prev_lt_q;
	logic     prev_lt_next;
	logic     load_ready;
	jse_run_t run;

	assign cfg_ready = 1'b1;
	assign in_ready  = !valid_s1 || load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			dot_q     <= 1'b0;
			prev_lt_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (cfg_valid) begin
				dot_q <= cfg_data;
			end
			if (valid_s1 && load_ready) begin
				prev_lt_q <= prev_lt_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_data;
		end
	end

	jse_encoder u_encoder (
		.word         (word_s1),
		.prev_lt      (prev_lt_q),
		.dot_mode     (dot_q),
		.run          (run),
		.prev_lt_next (prev_lt_next)
	);

	jse_serializer u_serializer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.run        (run),
		.load_ready (load_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_prev_lt_set: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && load_ready && (word_s1.operation == OpChar)
			&& (word_s1.char_byte == ChLess)) |=> prev_lt_q)
		else $error("look-behind flag not set after '<'");

	a_prev_lt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && load_ready && ((word_s1.operation == OpStart)
			|| (word_s1.operation == OpEnd))) |=> !prev_lt_q)
		else $error("look-behind flag not cleared at string boundary");

endmodule

// File: verif/json_string_escaper_tb.sv
`timescale 1ns / 100ps

module json_string_escaper_tb;
	import jse_pkg::*;

	localparam logic [1:0] OpVoid      = 2'd3;
	localparam int         SettleCycles = 8;
	localparam int         EndCycles    = 16;
	localparam int         WatchLimit   = 2000;

	typedef enum logic [1:0] {
		ActWord,
		ActCfg,
		ActDrain
	} act_kind_t;

	typedef struct {
		act_kind_t kind;
		jse_in_t   word;
		logic      cfg_val;
		logic      may_idle;
	} stim_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	jse_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	jse_out_t out_data;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	logic     cfg_data  = 1'b0;

	stim_t    word_queue[$];
	jse_out_t escaped_due[$];
	logic     model_dot        = 1'b0;
	logic     model_after_less = 1'b0;
	int       err_count        = 0;
	int       n_words          = 0;
	int       gap_left         = 0;
	logic     gap_armed        = 1'b1;
	int       settle_cnt       = 0;
	logic     rx_idle          = 1'b0;
	int       stall_left       = 0;
	int       quiet_cycles     = 0;

	json_string_escaper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void predict_escape(input jse_in_t w);
		logic [7:0] run [6];
		logic [7:0] c;
		jse_out_t   r_out;
		int         n;
		int         k;
		n = 0;
		c = w.char_byte;
		case (w.operation)
			OpStart, OpEnd: begin
				model_after_less = 1'b0;
				run[0] = ChQuote;
				n = 1;
			end
			OpChar: begin
				if (c < CtrlLimit) begin
					run[0] = ChBslash;
					n = 2;
					case (c)
						CtrlBs: run[1] = ChB;
						CtrlHt: run[1] = ChT;
						CtrlLf: run[1] = ChN;
						CtrlFf: run[1] = ChF;
						CtrlCr: run[1] = ChR;
						default: begin
							run[1] = ChU;
							run[2] = ChZero;
							run[3] = ChZero;
							run[4] = hex_char(c[7:4]);
							run[5] = hex_char(c[3:0]);
							n = 6;
						end
					endcase
				end else if (c == ChSlash && model_after_less) begin
					run[0] = ChBslash;
					run[1] = ChSlash;
					n = 2;
				end else if (c == ChBslash || c == ChQuote) begin
					run[0] = ChBslash;
					run[1] = c;
					n = 2;
				end else if (c == ChDot && model_dot) begin
					run[0] = ChUnder;
					n = 1;
				end else begin
					run[0] = c;
					n = 1;
				end
				model_after_less = (c == ChLess);
			end
			default: ;
		endcase
		for (k = 0; k < n; k++) begin
			r_out.out_byte    = run[k];
			r_out.last_of_run = (k == n - 1);
			escaped_due.push_back(r_out);
		end
	endfunction

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 8'($urandom_range(8'h20, 8'h7E));
		if (r < 57) return 8'($urandom_range(0, 31));
		if (r < 67) return 8'($urandom_range(8'h80, 8'hFF));
		if (r < 75) return ChDot;
		if (r < 82) return ChLess;
		if (r < 89) return ChSlash;
		if (r < 95) return ChQuote;
		return ChBslash;
	endfunction

	task automatic add_word(input logic [1:0] op, input logic [7:0] b, input logic idle);
		stim_t s;
		s.kind               = ActWord;
		s.word.operation     = op;
		s.word.char_byte     = b;
		s.cfg_val            = 1'b0;
		s.may_idle           = idle;
		word_queue.push_back(s);
		if (op != OpVoid) n_words++;
	endtask

	task automatic add_cfg(input logic v);
		stim_t s;
		s.kind     = ActCfg;
		s.word     = '0;
		s.cfg_val  = v;
		s.may_idle = 1'b0;
		word_queue.push_back(s);
	endtask

	task automatic add_string(input logic idle);
		int         r;
		int         len;
		int         k;
		logic [7:0] c;
		r   = $urandom_range(0, 9);
		len = $urandom_range(0, 10);
		if (r == 0) begin
			add_word(OpVoid, 8'($urandom_range(0, 255)), idle);
		end else if (r == 1) begin
			for (k = 0; k < int'($urandom_range(1, 3)); k++) begin
				add_word(OpChar, pick_char(), idle);
			end
		end else begin
			add_word(OpStart, 8'($urandom_range(0, 255)), idle);
			for (k = 0; k < len; k++) begin
				c = pick_char();
				add_word(OpChar, c, idle);
				if (c == ChLess && $urandom_range(0, 1) == 1) add_word(OpChar, ChSlash, idle);
				if ($urandom_range(0, 19) == 0) add_word(OpVoid, 8'($urandom_range(0, 255)), idle);
			end
			if (r != 2) add_word(OpEnd, 8'($urandom_range(0, 255)), idle);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		logic  nxt_valid;
		logic  nxt_cfg;
		stim_t act;
		if (!arst_n) begin
			in_valid         <= 1'b0;
			in_data          <= '0;
			cfg_valid        <= 1'b0;
			cfg_data         <= 1'b0;
			gap_left         <= 0;
			gap_armed        <= 1'b1;
			settle_cnt       <= 0;
			rx_idle          <= 1'b0;
			model_dot        = 1'b0;
			model_after_less = 1'b0;
		end else begin
			if (in_valid && in_ready) predict_escape(in_data);
			if (cfg_valid && cfg_ready) model_dot = cfg_data;
			nxt_valid = in_valid && !in_ready;
			nxt_cfg   = cfg_valid && !cfg_ready;
			if (escaped_due.size() == 0 && !in_valid) begin
				if (settle_cnt < SettleCycles) settle_cnt <= settle_cnt + 1;
			end else begin
				settle_cnt <= 0;
			end
			if (!nxt_valid && !nxt_cfg) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end else if (word_queue.size() != 0) begin
					act = word_queue[0];
					case (act.kind)
						ActWord: begin
							if (act.may_idle && gap_armed && $urandom_range(0, 4) == 0) begin
								gap_left  <= $urandom_range(0, 5);
								gap_armed <= 1'b0;
							end else begin
								void'(word_queue.pop_front());
								nxt_valid = 1'b1;
								in_data   <= act.word;
								rx_idle   <= act.may_idle;
								gap_armed <= 1'b1;
							end
						end
						ActCfg: begin
							if (settle_cnt >= SettleCycles) begin
								void'(word_queue.pop_front());
								nxt_cfg  = 1'b1;
								cfg_data <= act.cfg_val;
							end
						end
						ActDrain: begin
							if (escaped_due.size() == 0) void'(word_queue.pop_front());
						end
						default: ;
					endcase
				end
			end
			in_valid  <= nxt_valid;
			cfg_valid <= nxt_cfg;
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		jse_out_t want;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (escaped_due.size() == 0) begin
					err_count++;
					if (err_count <= 10) begin
						$display("unexpected word: out_byte %h last_of_run %b",
							out_data.out_byte, out_data.last_of_run);
					end
				end else begin
					want = escaped_due.pop_front();
					if (out_data.out_byte !== want.out_byte
							|| out_data.last_of_run !== want.last_of_run) begin
						err_count++;
						if (err_count <= 10) begin
							$display("mismatch: out_byte exp %h got %h, last_of_run exp %b got %b",
								want.out_byte, out_data.out_byte,
								want.last_of_run, out_data.last_of_run);
						end
					end
				end
			end
			if (stall_left != 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (rx_idle && $urandom_range(0, 4) == 0) begin
				out_ready  <= 1'b0;
				stall_left <= $urandom_range(0, 5);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= WatchLimit) begin
				$display("json_string_escaper_tb: done, errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int   goal;
		int   ph;
		logic idle;
		stim_t s;

		add_word(OpStart, 8'h00, 1'b1);
		add_word(OpChar, 8'h00, 1'b1);
		add_word(OpChar, CtrlBs, 1'b1);
		add_word(OpChar, CtrlHt, 1'b1);
		add_word(OpChar, CtrlLf, 1'b1);
		add_word(OpChar, CtrlFf, 1'b1);
		add_word(OpChar, CtrlCr, 1'b1);
		add_word(OpChar, 8'h1F, 1'b1);
		add_word(OpChar, CtrlLimit, 1'b1);
		add_word(OpChar, ChQuote, 1'b1);
		add_word(OpChar, ChBslash, 1'b1);
		add_word(OpChar, ChLess, 1'b1);
		add_word(OpChar, ChSlash, 1'b1);
		add_word(OpChar, ChSlash, 1'b1);
		add_word(OpChar, ChDot, 1'b1);
		add_word(OpChar, 8'h80, 1'b1);
		add_word(OpChar, 8'hFF, 1'b1);
		add_word(OpChar, ChLess, 1'b1);
		add_word(OpVoid, 8'hFF, 1'b1);
		add_word(OpChar, ChSlash, 1'b1);
		add_word(OpChar, ChLess, 1'b1);
		add_word(OpEnd, 8'hFF, 1'b1);
		add_word(OpChar, ChSlash, 1'b1);
		add_word(OpStart, 8'hFF, 1'b1);
		add_cfg(1'b1);
		add_word(OpChar, ChDot, 1'b1);
		add_word(OpChar, ChLess, 1'b1);
		add_word(OpChar, ChDot, 1'b1);
		add_word(OpEnd, 8'h55, 1'b1);

		// random phases: dot mode 1, 0, 1, then random with no idling
		for (ph = 0; ph < 4; ph++) begin
			if (ph == 1) add_cfg(1'b0);
			if (ph == 2) add_cfg(1'b1);
			if (ph == 3) add_cfg(1'($urandom_range(0, 1)));
			goal = n_words + ((ph == 3) ? 90 : 75);
			while (n_words < goal) begin
				idle = (ph != 3) && ($urandom_range(0, 3) != 0);
				add_string(idle);
				// hold off the sender until every escaped byte has drained
				if (ph == 0 && n_words >= goal - 45 && n_words < goal - 30) begin
					s.kind     = ActDrain;
					s.word     = '0;
					s.cfg_val  = 1'b0;
					s.may_idle = 1'b0;
					word_queue.push_back(s);
				end
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (word_queue.size() != 0 || in_valid || cfg_valid || escaped_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (EndCycles) @(negedge clk);
		if (escaped_due.size() != 0) begin
			err_count++;
			$display("missing words: %0d escaped bytes never arrived", escaped_due.size());
		end
		if (err_count == 0) begin
			$display("json_string_escaper_tb: done, clean");
		end else begin
			$display("json_string_escaper_tb: done, errors");
		end
		$finish;
	end

endmodule
